FILE: rtl/psu_pkg.sv
// Shared types, constants and the LFSR step function of the particle swarm update block.
package psu_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned W_W      = 17;
  localparam int unsigned C_W      = 18;
  localparam int unsigned R_W      = 16;
  localparam int unsigned MUL_A_W  = C_W + 1;
  localparam int unsigned MUL_B_W  = WORD_W + 1;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INERTIA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL   = 3'd5;

  localparam logic signed [WORD_W-1:0] UPPER_RST = 32'sd6553600;
  localparam logic signed [WORD_W-1:0] LOWER_RST = -32'sd6553600;
  localparam logic [W_W-1:0]           INERTIA_RST = 17'd45875;
  localparam logic [C_W-1:0]           ACCEL_RST   = 18'd98055;

  localparam logic [WORD_W-1:0]        LFSR_SEED = 32'd31;
  localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic              reseed;
    logic signed [31:0] fitness;
    logic signed [31:0] best_fitness_in;
    logic signed [31:0] best_x_in;
    logic signed [31:0] best_y_in;
    logic signed [31:0] pos_x_in;
    logic signed [31:0] pos_y_in;
    logic signed [31:0] vel_x_in;
    logic signed [31:0] vel_y_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] best_fitness_out;
    logic signed [31:0] best_x_out;
    logic signed [31:0] best_y_out;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic signed [31:0] swarm_best_x;
    logic signed [31:0] swarm_best_y;
    logic signed [31:0] swarm_best_fitness;
  } out_t;

  typedef struct packed {
    logic seed;
    logic step;
  } lfsr_ctl_t;

  // Taps at bits 0, 10, 30 and 31, shifting right with feedback into the top bit.
  function automatic logic [WORD_W-1:0] lfsr_step(input logic [WORD_W-1:0] g);
    logic fb;
    fb = g[0] ^ g[10] ^ g[30] ^ g[31];
    return {fb, g[WORD_W-1:1]};
  endfunction

endpackage

FILE: rtl/psu_lfsr.sv
// Random generator register with optional reseed and single-step advance.
module psu_lfsr
  import psu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lfsr_ctl_t         ctl,
  output logic [WORD_W-1:0] gen,
  output logic [WORD_W-1:0] gen_nxt
);

  logic [WORD_W-1:0] gen_r;
  logic [WORD_W-1:0] base;

  always_comb begin
    base    = ctl.seed ? LFSR_SEED : gen_r;
    gen_nxt = ctl.step ? lfsr_step(base) : base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
    end else begin
      gen_r <= gen_nxt;
    end
  end

  assign gen = gen_r;

endmodule

FILE: rtl/psu_mul.sv
// Shared signed multiplier with a registered product.
module psu_mul
  import psu_pkg::*;
(
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  op_a,
  input  logic signed [MUL_B_W-1:0]  op_b,
  output logic signed [PROD_W-1:0]   prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

FILE: rtl/particle_swarm_update.sv
// Top level of the particle swarm update block: sequencer, datapath and registers.
//
//   Channel   Direction  Handshake              Beat
//   in_       input      in_valid / in_stall    in_t: one load or one particle
//   out_      output     out_valid / out_stall  out_t: one updated particle
//   cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data: one register
//
// A load beat (mode 0) is absorbed in the cycle it is accepted and gives no result.
// A particle beat (mode 1) passes through a state for the best updates, then per axis the
// states for its five products on the one shared multiplier, the sum, velocity and position,
// and a final state that loads the result; the next beat is accepted once the block is idle.
// Reset is synchronous and active low; it restores the bounds and factors and clears the
// generator and the swarm best. in_stall is high while a particle is in work, including while
// its result waits for a full, stalled output register; a result already held there does not
// block a new beat.
module particle_swarm_update
  import psu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam int unsigned ACC_W = PROD_W + 2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_BEST = 4'd1;
  localparam logic [3:0] ST_CR1  = 4'd2;
  localparam logic [3:0] ST_CR2  = 4'd3;
  localparam logic [3:0] ST_WV   = 4'd4;
  localparam logic [3:0] ST_D1   = 4'd5;
  localparam logic [3:0] ST_D2   = 4'd6;
  localparam logic [3:0] ST_SUM  = 4'd7;
  localparam logic [3:0] ST_VEL  = 4'd8;
  localparam logic [3:0] ST_POS  = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  // Configuration registers.
  logic signed [WORD_W-1:0] upper_x_r, lower_x_r, upper_y_r, lower_y_r;
  logic [W_W-1:0]           inertia_r;
  logic [C_W-1:0]           accel_r;

  // Swarm state.
  logic signed [WORD_W-1:0] gbest_x_r, gbest_y_r, gbest_f_r;

  // Sequencer and working registers.
  logic [3:0]               state_r, state_nxt;
  logic                     axis_r;
  in_t                      item_r;
  logic signed [WORD_W-1:0] pbest_x_r, pbest_y_r, pbest_f_r;
  logic [C_W-1:0]           cr1_r, cr2_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [WORD_W-1:0] vel_r;
  logic signed [WORD_W-1:0] nvel_x_r, nvel_y_r, npos_x_r, npos_y_r;
  logic                     out_valid_r;
  out_t                     out_data_r;

  logic                     in_accept;
  logic                     out_free;
  lfsr_ctl_t                lfsr_ctl;
  logic [WORD_W-1:0]        gen, gen_nxt;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   term;

  logic signed [WORD_W-1:0] vel_sel, pos_sel, pb_sel, gb_sel, ub_sel, lb_sel;
  logic signed [MUL_B_W-1:0] d1, d2;
  logic signed [WORD_W-1:0] vel_sat;
  logic signed [WORD_W:0]   pos_sum;
  logic signed [WORD_W-1:0] pos_sat, pos_clamped;
  logic                     acc_fits;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The generator is stepped once on a load beat and once per draw in a particle.
  always_comb begin
    lfsr_ctl.seed = in_accept && (in_data.mode == MODE_LOAD) && in_data.reseed;
    lfsr_ctl.step = (in_accept && (in_data.mode == MODE_LOAD))
                    || (state_r == ST_CR1) || (state_r == ST_CR2);
  end

  psu_lfsr u_lfsr (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lfsr_ctl),
    .gen     (gen),
    .gen_nxt (gen_nxt)
  );

  // Per-axis operand selection; axis 0 is x, axis 1 is y.
  always_comb begin
    vel_sel = axis_r ? item_r.vel_y_in : item_r.vel_x_in;
    pos_sel = axis_r ? item_r.pos_y_in : item_r.pos_x_in;
    pb_sel  = axis_r ? pbest_y_r : pbest_x_r;
    gb_sel  = axis_r ? gbest_y_r : gbest_x_r;
    ub_sel  = axis_r ? upper_y_r : upper_x_r;
    lb_sel  = axis_r ? lower_y_r : lower_x_r;
    d1 = {pb_sel[WORD_W-1], pb_sel} - {pos_sel[WORD_W-1], pos_sel};
    d2 = {gb_sel[WORD_W-1], gb_sel} - {pos_sel[WORD_W-1], pos_sel};
  end

  // Multiplier operands: two draws scaled by c, then w*v, cr1*d1 and cr2*d2.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      ST_CR1, ST_CR2: begin
        op_a = {1'b0, accel_r};
        op_b = {{(MUL_B_W-R_W){1'b0}}, gen_nxt[WORD_W-1 -: R_W]};
      end
      ST_WV: begin
        op_a = {{(MUL_A_W-W_W){1'b0}}, inertia_r};
        op_b = {vel_sel[WORD_W-1], vel_sel};
      end
      ST_D1: begin
        op_a = {1'b0, cr1_r};
        op_b = d1;
      end
      ST_D2: begin
        op_a = {1'b0, cr2_r};
        op_b = d2;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  psu_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // The arithmetic shift rounds each product toward minus infinity.
  always_comb begin
    prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    term     = prod_ext >>> FRAC_BITS;
  end

  // Saturation of the velocity sum, then move, saturate and clamp the position.
  always_comb begin
    acc_fits = (&acc_r[ACC_W-1:WORD_W-1]) || !(|acc_r[ACC_W-1:WORD_W-1]);
    vel_sat  = acc_fits ? acc_r[WORD_W-1:0] : (acc_r[ACC_W-1] ? WORD_MIN : WORD_MAX);
    pos_sum  = {pos_sel[WORD_W-1], pos_sel} + {vel_r[WORD_W-1], vel_r};
    if (pos_sum[WORD_W] != pos_sum[WORD_W-1]) begin
      pos_sat = pos_sum[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      pos_sat = pos_sum[WORD_W-1:0];
    end
    pos_clamped = (pos_sat > ub_sel) ? ub_sel : pos_sat;
    if (pos_clamped < lb_sel) begin
      pos_clamped = lb_sel;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_data.mode == MODE_UPDATE)) begin
          state_nxt = ST_BEST;
        end
      end
      ST_BEST: state_nxt = ST_CR1;
      ST_CR1:  state_nxt = ST_CR2;
      ST_CR2:  state_nxt = ST_WV;
      ST_WV:   state_nxt = ST_D1;
      ST_D1:   state_nxt = ST_D2;
      ST_D2:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_VEL;
      ST_VEL:  state_nxt = ST_POS;
      ST_POS:  state_nxt = axis_r ? ST_DONE : ST_CR1;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and swarm best.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
      upper_x_r   <= UPPER_RST;
      lower_x_r   <= LOWER_RST;
      upper_y_r   <= UPPER_RST;
      lower_y_r   <= LOWER_RST;
      inertia_r   <= INERTIA_RST;
      accel_r     <= ACCEL_RST;
      gbest_x_r   <= '0;
      gbest_y_r   <= '0;
      gbest_f_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_BEST) begin
        axis_r <= 1'b0;
      end else if (state_r == ST_POS) begin
        axis_r <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_UPPER_X: upper_x_r <= cfg_data;
          CFG_LOWER_X: lower_x_r <= cfg_data;
          CFG_UPPER_Y: upper_y_r <= cfg_data;
          CFG_LOWER_Y: lower_y_r <= cfg_data;
          CFG_INERTIA: inertia_r <= cfg_data[W_W-1:0];
          CFG_ACCEL:   accel_r   <= cfg_data[C_W-1:0];
          default: ;
        endcase
      end
      // A load beat replaces the swarm best; a particle replaces it on a strictly
      // lower fitness.
      if (in_accept && (in_data.mode == MODE_LOAD)) begin
        gbest_x_r <= in_data.pos_x_in;
        gbest_y_r <= in_data.pos_y_in;
        gbest_f_r <= in_data.fitness;
      end else if (state_r == ST_BEST && item_r.fitness < gbest_f_r) begin
        gbest_x_r <= item_r.pos_x_in;
        gbest_y_r <= item_r.pos_y_in;
        gbest_f_r <= item_r.fitness;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    unique case (state_r)
      ST_BEST: begin
        if (item_r.fitness < item_r.best_fitness_in) begin
          pbest_x_r <= item_r.pos_x_in;
          pbest_y_r <= item_r.pos_y_in;
          pbest_f_r <= item_r.fitness;
        end else begin
          pbest_x_r <= item_r.best_x_in;
          pbest_y_r <= item_r.best_y_in;
          pbest_f_r <= item_r.best_fitness_in;
        end
      end
      ST_CR2: cr1_r <= prod[R_W +: C_W];
      ST_WV:  cr2_r <= prod[R_W +: C_W];
      ST_D1:  acc_r <= term;
      ST_D2:  acc_r <= acc_r + term;
      ST_SUM: acc_r <= acc_r + term;
      ST_VEL: vel_r <= vel_sat;
      ST_POS: begin
        if (axis_r) begin
          nvel_y_r <= vel_r;
          npos_y_r <= pos_clamped;
        end else begin
          nvel_x_r <= vel_r;
          npos_x_r <= pos_clamped;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r.best_fitness_out   <= pbest_f_r;
          out_data_r.best_x_out         <= pbest_x_r;
          out_data_r.best_y_out         <= pbest_y_r;
          out_data_r.pos_x_out          <= npos_x_r;
          out_data_r.pos_y_out          <= npos_y_r;
          out_data_r.vel_x_out          <= nvel_x_r;
          out_data_r.vel_y_out          <= nvel_y_r;
          out_data_r.swarm_best_x       <= gbest_x_r;
          out_data_r.swarm_best_y       <= gbest_y_r;
          out_data_r.swarm_best_fitness <= gbest_f_r;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // A particle beat starts the best update in the following cycle.
  a_particle_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_data.mode == MODE_UPDATE)) |=> (state_r == ST_BEST))
    else $error("particle beat did not start the sequencer");

  // Finishing a particle fills the output register and frees the input side.
  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid && state_r == ST_IDLE))
    else $error("finished particle not moved to the output register");

  // A reseeding load leaves the generator one step past the seed.
  a_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_ctl.seed |=> (gen == lfsr_step(LFSR_SEED)))
    else $error("reseed did not load and step the generator");

  // A generator holding zero stays at zero unless it is reseeded.
  a_zero_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (gen == '0 && !lfsr_ctl.seed) |=> (gen == '0))
    else $error("zero generator left zero without a reseed");
`endif

endmodule

FILE: dv/particle_swarm_update_tb.sv
// Self-checking testbench of the particle swarm update block with its own bit-exact predictor.
`timescale 1ns / 100ps

module particle_swarm_update_tb;
  import psu_pkg::*;

  // The block runs at its default of 16 fraction bits; the predictor uses the same figure.
  localparam int FRAC = 16;

  // Random beats per configuration phase; six phases give about 1300 beats in all.
  localparam int PHASES    = 6;
  localparam int PER_PHASE = 217;

  // The slowest correct run is about 1300 particles plus sender gaps and receiver stalls;
  // the limit allows several times that.
  localparam int LIMIT = 600000;

  // A particle's work is shorter than this quiet stretch, so after the last result the block
  // is idle before a register write.
  localparam int QUIET = 24;

  // Register indexes that select no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  // Feedback taps of the generator: bits 31, 30, 10 and 0.
  localparam logic [WORD_W-1:0] TAP_MASK = 32'hC000_0401;

  localparam int ONE = 65536;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  particle_swarm_update #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Shadow copy of the block's registers and state. It changes only at the clock edge
  // where a beat or a register write is accepted.
  logic signed [WORD_W-1:0] bound_hi_x, bound_lo_x, bound_hi_y, bound_lo_y;
  logic [W_W-1:0]           inertia_q;
  logic [C_W-1:0]           accel_q;
  logic [WORD_W-1:0]        lfsr_q;
  logic signed [WORD_W-1:0] gbest_x, gbest_y, gbest_fit;

  // Particle results predicted but not yet seen on the output, oldest first.
  out_t updates_due[$];

  int  bad_fields;
  int  results_seen;
  int  cycles;
  // While set, neither side inserts gaps or stalls.
  bit  calm;

  // Directed stimulus: either a register write or a beat, the latter with an optional
  // hand-written result that replaces the prediction.
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [WORD_W-1:0]    reg_val;
    in_t                  beat;
    bit                   typed;
    out_t                 want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void report_mismatch(string what);
    bad_fields++;
    if (bad_fields <= 50) begin
      $display("MISMATCH at cycle %0d: %s", cycles, what);
    end
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] got,
                                      logic [WORD_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d", results_seen, name,
                                $signed(got), $signed(want)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // The generator shifts right with the feedback entering the top bit. A draw steps it
  // first and then takes the top half as an unsigned fraction. A zero generator stays zero.
  function automatic longint next_draw();
    lfsr_q = {^(lfsr_q & TAP_MASK), lfsr_q[WORD_W-1:1]};
    return longint'(lfsr_q[WORD_W-1:R_W]);
  endfunction

  function automatic longint sat_word(longint v);
    if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
    if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
    return v;
  endfunction

  // New velocity of one axis. Each draw is scaled by the acceleration factor, and every
  // product drops its fraction bits rounding toward minus infinity, which is what an
  // arithmetic shift of a signed 64-bit value does.
  function automatic longint axis_velocity(longint vel, longint pos, longint pb, longint gb);
    longint cr1, cr2, acc;
    cr1 = (longint'(accel_q) * next_draw()) >>> R_W;
    cr2 = (longint'(accel_q) * next_draw()) >>> R_W;
    acc = ((longint'(inertia_q) * vel) >>> FRAC)
        + ((cr1 * (pb - pos)) >>> FRAC)
        + ((cr2 * (gb - pos)) >>> FRAC);
    return sat_word(acc);
  endfunction

  // The upper bound is applied first, so with crossed bounds the lower one wins.
  function automatic logic [WORD_W-1:0] moved(longint pos, longint vel, longint hi,
                                              longint lo);
    longint p;
    p = sat_word(pos + vel);
    if (p > hi) p = hi;
    if (p < lo) p = lo;
    return p[WORD_W-1:0];
  endfunction

  // Applies one accepted beat to the shadow state; returns 1 with the result for a particle.
  function automatic bit swarm_step(input in_t b, output out_t r);
    longint fit, pbf, pbx, pby, px, py, nvx, nvy;
    r = '0;
    if (b.mode == MODE_LOAD) begin
      gbest_x   = b.pos_x_in;
      gbest_y   = b.pos_y_in;
      gbest_fit = b.fitness;
      if (b.reseed) lfsr_q = LFSR_SEED;
      void'(next_draw());
      return 1'b0;
    end
    // A particle beat ignores reseed.
    fit = $signed(b.fitness);
    pbf = $signed(b.best_fitness_in);
    pbx = $signed(b.best_x_in);
    pby = $signed(b.best_y_in);
    px  = $signed(b.pos_x_in);
    py  = $signed(b.pos_y_in);
    // Both bests move only on a strictly lower fitness.
    if (fit < pbf) begin
      pbx = px;
      pby = py;
      pbf = fit;
    end
    if ($signed(b.fitness) < gbest_fit) begin
      gbest_x   = b.pos_x_in;
      gbest_y   = b.pos_y_in;
      gbest_fit = b.fitness;
    end
    // The x axis takes the first two draws, the y axis the next two.
    nvx = axis_velocity($signed(b.vel_x_in), px, pbx, gbest_x);
    nvy = axis_velocity($signed(b.vel_y_in), py, pby, gbest_y);
    r.best_fitness_out   = pbf[WORD_W-1:0];
    r.best_x_out         = pbx[WORD_W-1:0];
    r.best_y_out         = pby[WORD_W-1:0];
    r.pos_x_out          = moved(px, nvx, bound_hi_x, bound_lo_x);
    r.pos_y_out          = moved(py, nvy, bound_hi_y, bound_lo_y);
    r.vel_x_out          = nvx[WORD_W-1:0];
    r.vel_y_out          = nvy[WORD_W-1:0];
    r.swarm_best_x       = gbest_x;
    r.swarm_best_y       = gbest_y;
    r.swarm_best_fitness = gbest_fit;
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    case (idx)
      CFG_UPPER_X: bound_hi_x = val;
      CFG_LOWER_X: bound_lo_x = val;
      CFG_UPPER_Y: bound_hi_y = val;
      CFG_LOWER_Y: bound_lo_y = val;
      CFG_INERTIA: inertia_q  = val[W_W-1:0];
      CFG_ACCEL:   accel_q    = val[C_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus values
  // ---------------------------------------------------------------------------

  // Mostly values around the clamp range, with extremes and full-width words mixed in.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2, 3: return $urandom();
      default: return $urandom_range(0, 24_000_000) - 32'd12_000_000;
    endcase
  endfunction

  function automatic in_t random_beat();
    in_t b;
    b.mode            = ($urandom_range(0, 99) < 15) ? MODE_LOAD : MODE_UPDATE;
    b.reseed          = ($urandom_range(0, 99) < 30);
    b.fitness         = pick_word();
    b.best_fitness_in = pick_word();
    b.best_x_in       = pick_word();
    b.best_y_in       = pick_word();
    b.pos_x_in        = pick_word();
    b.pos_y_in        = pick_word();
    b.vel_x_in        = pick_word();
    b.vel_y_in        = pick_word();
    // Ties and near ties with both bests exercise the strict comparisons.
    case ($urandom_range(0, 7))
      0: b.fitness = b.best_fitness_in;
      1: b.fitness = gbest_fit;
      2: b.fitness = b.best_fitness_in - 1;
      3: b.fitness = gbest_fit - 1;
      default: ;
    endcase
    return b;
  endfunction

  function automatic in_t particle(int fit, int pbf, int bx, int by, int px, int py,
                                   int vx, int vy);
    in_t b;
    b                 = '0;
    b.mode            = MODE_UPDATE;
    b.fitness         = fit;
    b.best_fitness_in = pbf;
    b.best_x_in       = bx;
    b.best_y_in       = by;
    b.pos_x_in        = px;
    b.pos_y_in        = py;
    b.vel_x_in        = vx;
    b.vel_y_in        = vy;
    return b;
  endfunction

  // The fields that a load ignores carry random bits.
  function automatic in_t swarm_load(bit rs, int fit, int gx, int gy);
    in_t b;
    b          = random_beat();
    b.mode     = MODE_LOAD;
    b.reseed   = rs;
    b.fitness  = fit;
    b.pos_x_in = gx;
    b.pos_y_in = gy;
    return b;
  endfunction

  function automatic void add_item(in_t b, bit typed = 1'b0, out_t want = '0);
    plan_row_t row;
    row = '{is_reg: 1'b0, reg_idx: '0, reg_val: '0, beat: b, typed: typed, want: want};
    plan.push_back(row);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    plan_row_t row;
    row = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, beat: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offers one input beat. Gaps are inserted at falling edges, the beat is held until a
  // rising edge sees in_stall low, and the shadow state moves at that same edge. Valid
  // stays high after acceptance so that back-to-back beats need no extra assignment.
  task automatic put_item(in_t b, bit typed, out_t want);
    out_t due;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (swarm_step(b, due)) updates_due.push_back(typed ? want : due);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drops valid, waits for every predicted result, then lets the block run dry. Loads give
  // no result, so the quiet stretch covers a particle still in work behind them.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (updates_due.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  // The receiver stalls at random, changing only on falling edges.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(0, 99) < 29);
    end
  end

  // Every result beat taken at a rising edge is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (updates_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no particle update due",
                                  results_seen));
      end else begin
        want = updates_due.pop_front();
        check_field("best_fitness_out", out_data.best_fitness_out, want.best_fitness_out);
        check_field("best_x_out", out_data.best_x_out, want.best_x_out);
        check_field("best_y_out", out_data.best_y_out, want.best_y_out);
        check_field("pos_x_out", out_data.pos_x_out, want.pos_x_out);
        check_field("pos_y_out", out_data.pos_y_out, want.pos_y_out);
        check_field("vel_x_out", out_data.vel_x_out, want.vel_x_out);
        check_field("vel_y_out", out_data.vel_y_out, want.vel_y_out);
        check_field("swarm_best_x", out_data.swarm_best_x, want.swarm_best_x);
        check_field("swarm_best_y", out_data.swarm_best_y, want.swarm_best_y);
        check_field("swarm_best_fitness", out_data.swarm_best_fitness,
                    want.swarm_best_fitness);
      end
      results_seen++;
    end
  end

  // Watchdog: a run that hangs ends here as a failure.
  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_flow
    in_t b;
    int  waited;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    bad_fields   = 0;
    results_seen = 0;

    // Shadow state as it stands after reset.
    bound_hi_x = UPPER_RST;
    bound_lo_x = LOWER_RST;
    bound_hi_y = UPPER_RST;
    bound_lo_y = LOWER_RST;
    inertia_q  = INERTIA_RST;
    accel_q    = ACCEL_RST;
    lfsr_q     = '0;
    gbest_x    = '0;
    gbest_y    = '0;
    gbest_fit  = '0;

    // Directed part. Right after reset the generator is zero, so every draw is zero and
    // only the inertia term moves a particle; those rows have hand-written results.
    add_item(particle(5, 3, 7, -7, 100, -100, 0, 0), 1'b1,
             out_t'{3, 7, -7, 100, -100, 0, 0, 0, 0, 0});
    // Lowest fitness takes over both bests; extreme positions clamp to the default bounds.
    add_item(particle(WORD_MIN, 0, 1, 1, WORD_MAX, WORD_MIN, 0, 0), 1'b1,
             out_t'{WORD_MIN, WORD_MAX, WORD_MIN, UPPER_RST, LOWER_RST, 0, 0,
                    WORD_MAX, WORD_MIN, WORD_MIN});
    // A fitness equal to both bests changes neither of them.
    add_item(particle(WORD_MIN, WORD_MIN, 11, 12, 0, 0, 0, 0), 1'b1,
             out_t'{WORD_MIN, 11, 12, 0, 0, 0, 0, WORD_MAX, WORD_MIN, WORD_MIN});
    add_item(particle(0, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX,
                      WORD_MIN));
    // Reseed on a particle beat must be ignored, leaving the generator at zero.
    b        = particle(-1, 0, ONE, -ONE, 0, 0, 3 * ONE, -3 * ONE);
    b.reseed = 1'b1;
    add_item(b);
    // A load without reseed keeps a zero generator at zero.
    add_item(swarm_load(1'b0, 1000, ONE, -ONE));
    add_item(particle(2000, 5000, 2 * ONE, 2 * ONE, -ONE, ONE, ONE, -ONE));
    // Reseed, after which the draws are live.
    add_item(swarm_load(1'b1, WORD_MAX, 3 * ONE, -2 * ONE));
    add_item(particle(10, 20, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN));
    add_item(particle(WORD_MAX, WORD_MAX, 0, 0, ONE, ONE, 0, 0));
    add_item(particle(WORD_MAX - 1, WORD_MAX, -ONE, ONE, 2 * ONE, -2 * ONE, ONE, ONE));
    add_item(particle(-5 * ONE, 0, ONE, ONE, 4 * ONE, -4 * ONE, -ONE, ONE));
    // Crossed bounds on x, then on y: the lower bound wins.
    add_reg(CFG_LOWER_X, 10 * ONE);
    add_reg(CFG_UPPER_X, -10 * ONE);
    add_item(particle(0, 0, 0, 0, 0, 0, 0, 0));
    add_item(particle(0, 0, 0, 0, WORD_MAX, 0, WORD_MAX, 0));
    add_reg(CFG_LOWER_Y, ONE);
    add_reg(CFG_UPPER_Y, -ONE);
    add_item(particle(7, 9, ONE, ONE, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    add_reg(CFG_UPPER_X, UPPER_RST);
    add_reg(CFG_LOWER_X, LOWER_RST);
    add_reg(CFG_UPPER_Y, UPPER_RST);
    add_reg(CFG_LOWER_Y, LOWER_RST);
    add_item(swarm_load(1'b1, WORD_MIN, -ONE, ONE));
    add_item(particle(WORD_MIN, WORD_MIN, 3 * ONE, -3 * ONE, ONE, -ONE, 2 * ONE, -2 * ONE));

    // Synchronous reset, released on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        put_item(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    // Random part, one register setting per phase; registers change only when idle.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      calm = 1'b0;
      case (p)
        1: begin
          // Widest bounds and largest factors; the masked factor bits are all set.
          write_reg(CFG_UPPER_X, WORD_MAX);
          write_reg(CFG_LOWER_X, WORD_MIN);
          write_reg(CFG_UPPER_Y, WORD_MAX);
          write_reg(CFG_LOWER_Y, WORD_MIN);
          write_reg(CFG_INERTIA, 32'hFFFF_FFFF);
          write_reg(CFG_ACCEL, 32'hFFFF_FFFF);
        end
        2: begin
          // Zero factors and a narrow box, run without any gaps or stalls.
          write_reg(CFG_UPPER_X, ONE);
          write_reg(CFG_LOWER_X, -ONE);
          write_reg(CFG_UPPER_Y, ONE);
          write_reg(CFG_LOWER_Y, -ONE);
          write_reg(CFG_INERTIA, '0);
          write_reg(CFG_ACCEL, '0);
          calm = 1'b1;
        end
        3: begin
          write_reg(CFG_UPPER_X, -3 * ONE);
          write_reg(CFG_LOWER_X, 3 * ONE);
          write_reg(CFG_UPPER_Y, pick_word());
          write_reg(CFG_LOWER_Y, pick_word());
          write_reg(CFG_INERTIA, ONE);
          write_reg(CFG_ACCEL, 2 * ONE);
        end
        4: begin
          write_reg(CFG_UPPER_X, $urandom());
          write_reg(CFG_LOWER_X, $urandom());
          write_reg(CFG_UPPER_Y, $urandom());
          write_reg(CFG_LOWER_Y, $urandom());
          write_reg(CFG_INERTIA, $urandom());
          write_reg(CFG_ACCEL, $urandom());
          write_reg(CFG_SPARE_A, $urandom());
          write_reg(CFG_SPARE_B, $urandom());
        end
        5: begin
          write_reg(CFG_UPPER_X, UPPER_RST);
          write_reg(CFG_LOWER_X, LOWER_RST);
          write_reg(CFG_UPPER_Y, UPPER_RST);
          write_reg(CFG_LOWER_Y, LOWER_RST);
          write_reg(CFG_INERTIA, WORD_W'(INERTIA_RST));
          write_reg(CFG_ACCEL, WORD_W'(ACCEL_RST));
        end
        default: ;
      endcase
      for (int n = 0; n < PER_PHASE; n++) begin
        put_item(random_beat(), 1'b0, '0);
      end
    end

    // Drain: wait a bounded time for the last results, then for the block to go quiet.
    @(negedge clk);
    in_valid <= 1'b0;
    calm     = 1'b0;
    waited   = 0;
    while (updates_due.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (updates_due.size() != 0) begin
      report_mismatch($sformatf("%0d particle updates never came out", updates_due.size()));
    end
    repeat (40) @(posedge clk);

    if (bad_fields == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
